### hw/rtl/nsp_pkg.sv
`default_nettype none

package nsp_pkg;

	localparam int FRAC_BITS_DEF  = 15;
	localparam int SINE_DEPTH_DEF = 512;

	localparam int BYTE_W     = 8;
	localparam int SCALE_W    = 11;
	localparam int CENTER_W   = 12;
	localparam int COORD_W    = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int OUT_DATA_W = 80;

	localparam logic [CFG_IDX_W-1:0] REG_VIEW_SCALE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_FIRST_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_SECOND_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_THIRD_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW      = 3'd4;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_RS,
		S_RZ,
		S_Y,
		S_X,
		S_PZ,
		S_PY,
		S_PX,
		S_OUT
	} state_t;

	function automatic longint unsigned taylor_div(int n);
		case (n)
			1: return 64'd6;
			2: return 64'd20;
			3: return 64'd42;
			4: return 64'd72;
			5: return 64'd110;
			6: return 64'd156;
			7: return 64'd210;
			default: return 64'd1;
		endcase
	endfunction

	// Restoring long division, used only while the tables are built.
	function automatic longint unsigned long_div(longint unsigned num,
			longint unsigned den);
		longint unsigned quot;
		longint unsigned remd;
		quot = 0;
		remd = 0;
		for (int i = 63; i >= 0; i--) begin
			remd = (remd << 1) | ((num >> i) & 64'd1);
			quot = quot << 1;
			if (remd >= den) begin
				remd = remd - den;
				quot = quot | 64'd1;
			end
		end
		return quot;
	endfunction

	// Taylor series of sin in Q30 with truncating steps, rounded half up to Q1.fb.
	function automatic longint sine_from_x(longint unsigned x, int fb);
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = long_div((term * x2) >> 30, taylor_div(n));
			if ((n & 1) == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return (sum + (longint'(1) <<< (29 - fb))) >>> (30 - fb);
	endfunction

	// Integer square root with rounding, ties going up.
	function automatic longint unsigned root_round(longint unsigned n_in);
		longint unsigned n;
		longint unsigned res;
		longint unsigned bitv;
		n = n_in;
		res = 0;
		bitv = longint'(1) << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		if (n > res)
			res = res + 1;
		return res;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/nsp_sine_rom.sv
`default_nettype none

module nsp_sine_rom #(
	parameter int FRAC_BITS        = nsp_pkg::FRAC_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = nsp_pkg::SINE_DEPTH_DEF
) (
	input  wire                                           clk,
	input  wire  [$clog2(2*SINE_TABLE_DEPTH)-1:0]         idx,
	output logic signed [FRAC_BITS+1:0]                   value
);
	import nsp_pkg::*;

	localparam int QUARTER = SINE_TABLE_DEPTH / 4;
	localparam int SW      = FRAC_BITS + 2;
	localparam int IW      = $clog2(2 * SINE_TABLE_DEPTH);
	localparam int RW      = $clog2(QUARTER + 1);

	localparam logic [IW-1:0] DEPTH_I = IW'(SINE_TABLE_DEPTH);
	localparam logic [IW-1:0] Q1_I    = IW'(QUARTER);
	localparam logic [IW-1:0] Q2_I    = IW'(2 * QUARTER);
	localparam logic [IW-1:0] Q3_I    = IW'(3 * QUARTER);
	localparam logic [IW-1:0] Q4_I    = IW'(4 * QUARTER);

	logic signed [SW-1:0] rom [QUARTER+1];

	for (genvar j = 0; j <= QUARTER; j++) begin : g_rom
		localparam longint unsigned X = HALF_PI_Q30 * longint'(j) / QUARTER;
		localparam longint V = sine_from_x(X, FRAC_BITS);
		assign rom[j] = V[SW-1:0];
	end

	logic [IW-1:0] wrapped;
	logic [IW-1:0] rem;
	logic [IW-1:0] addr;
	logic          odd;
	logic          neg;
	logic signed [SW-1:0] mag;
	logic signed [SW-1:0] val;

	always_comb begin
		wrapped = (idx >= DEPTH_I) ? idx - DEPTH_I : idx;
		if (wrapped < Q1_I) begin
			rem = wrapped;
			odd = 1'b0;
			neg = 1'b0;
		end else if (wrapped < Q2_I) begin
			rem = wrapped - Q1_I;
			odd = 1'b1;
			neg = 1'b0;
		end else if (wrapped < Q3_I) begin
			rem = wrapped - Q2_I;
			odd = 1'b0;
			neg = 1'b1;
		end else if (wrapped < Q4_I) begin
			rem = wrapped - Q3_I;
			odd = 1'b1;
			neg = 1'b1;
		end else begin
			rem = wrapped - Q4_I;
			odd = 1'b0;
			neg = 1'b1;
		end
		addr = odd ? (Q1_I - rem) : rem;
		mag = rom[addr[RW-1:0]];
		val = neg ? -mag : mag;
	end

	always_ff @(posedge clk) begin
		value <= val;
	end

endmodule

`default_nettype wire

### hw/rtl/nsp_mul.sv
`default_nettype none

module nsp_mul #(
	parameter int W = 17
) (
	input  wire                    clk,
	input  wire                    en,
	input  wire  signed [W-1:0]    a,
	input  wire  signed [W-1:0]    b,
	output logic signed [2*W-1:0]  prod
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod <= a * b;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/noise_sphere_point_plotter.sv
`default_nettype none

// Noise-sphere point plotter. Each byte transfer on the input stream is
// stored as history; from the third byte on, the byte and the two before it
// give one point that is returned as three screen views in one output
// transfer. From the accepting edge to the output register, a point passes
// through one table fetch, seven products on a single shared multiplier and
// a step that loads the result and is held while the previous point still
// waits in the output register. The input is not ready while a point is in
// progress and is ready again once the result is loaded. The first two bytes
// after reset only fill the history and do not start a point. Configuration
// registers may be written only while no point is in progress.
module noise_sphere_point_plotter #(
	parameter int FRAC_BITS        = nsp_pkg::FRAC_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = nsp_pkg::SINE_DEPTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [nsp_pkg::BYTE_W-1:0]         s_tdata,  // sample_byte
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// first_view_col, first_view_row, second_view_col, second_view_row,
	// third_view_col, third_view_row, two zero bits
	output logic [nsp_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  wire                                cfg_we,
	input  wire  [nsp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [nsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import nsp_pkg::*;

	localparam int SW         = FRAC_BITS + 2;
	localparam int MW         = (SW > 12) ? SW : 12;
	localparam int PW         = 2 * MW;
	localparam int ROOT_W     = FRAC_BITS + 1;
	localparam int QUARTER    = SINE_TABLE_DEPTH / 4;
	localparam int THETA_STEP = SINE_TABLE_DEPTH / 512;
	localparam int IW         = $clog2(2 * SINE_TABLE_DEPTH);

	localparam logic [IW-1:0] QUARTER_I  = IW'(QUARTER);
	localparam logic [IW-1:0] PHI_MUL_I  = IW'(2 * THETA_STEP);
	localparam logic [IW-1:0] THETA_MUL_I = IW'(THETA_STEP);
	localparam logic [1:0]    SEEN_FULL  = 2'd2;
	localparam logic signed [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

	logic [ROOT_W-1:0] root_rom [256];

	for (genvar k = 0; k < 256; k++) begin : g_root
		localparam longint unsigned RV = root_round(longint'(k) << (2 * FRAC_BITS - 8));
		assign root_rom[k] = RV[ROOT_W-1:0];
	end

	state_t state_q, state_nxt;

	logic [SCALE_W-1:0]  view_scale_q;
	logic [CENTER_W-1:0] center_first_x_q;
	logic [CENTER_W-1:0] center_second_x_q;
	logic [CENTER_W-1:0] center_third_x_q;
	logic [CENTER_W-1:0] center_row_q;
	logic [BYTE_W-1:0]   oldest_byte_q;
	logic [BYTE_W-1:0]   middle_byte_q;
	logic [1:0]          bytes_seen_q;
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [BYTE_W-1:0]   c_q;
	logic [IW-1:0]       phi_idx_q;
	logic [IW-1:0]       theta_idx_q;
	logic [ROOT_W-1:0]   r_q;
	logic signed [SW-1:0] rs_q;
	logic signed [SW-1:0] x_q;
	logic signed [SW-1:0] y_q;
	logic signed [SW-1:0] z_q;
	logic signed [COORD_W-1:0] px_c;
	logic signed [COORD_W-1:0] py_q;
	logic signed [COORD_W-1:0] pz_q;

	logic               accept;
	logic               out_free;
	logic               load_out;
	logic               mul_en;
	logic [IW-1:0]      sine_idx;
	logic signed [SW-1:0] sine_val;
	logic signed [MW-1:0] op_a;
	logic signed [MW-1:0] op_b;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] biased;
	logic signed [PW-1:0] floor_full;
	logic signed [PW-1:0] mag_full;
	logic signed [PW-1:0] shift_full;
	logic signed [PW-1:0] proj_full;
	logic signed [SW-1:0] rnd_v;

	logic signed [CENTER_W+1:0] sum_fc, sum_fr, sum_sc, sum_sr, sum_tc, sum_tr;
	logic signed [COORD_W-1:0]  fc, fr, sc, sr, tc, tr;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		mul_en    = 1'b0;
		load_out  = 1'b0;
		sine_idx  = phi_idx_q;
		op_a      = MW'(r_q);
		op_b      = MW'(sine_val);
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && bytes_seen_q == SEEN_FULL) begin
					state_nxt = S_LOAD;
				end
			end
			S_LOAD: begin
				sine_idx  = phi_idx_q;
				state_nxt = S_RS;
			end
			S_RS: begin
				sine_idx  = phi_idx_q + QUARTER_I;
				mul_en    = 1'b1;
				state_nxt = S_RZ;
			end
			S_RZ: begin
				sine_idx  = theta_idx_q;
				mul_en    = 1'b1;
				state_nxt = S_Y;
			end
			S_Y: begin
				sine_idx  = theta_idx_q + QUARTER_I;
				op_a      = MW'(rs_q);
				mul_en    = 1'b1;
				state_nxt = S_X;
			end
			S_X: begin
				op_a      = MW'(rs_q);
				mul_en    = 1'b1;
				state_nxt = S_PZ;
			end
			S_PZ: begin
				op_a      = MW'(view_scale_q);
				op_b      = MW'(z_q);
				mul_en    = 1'b1;
				state_nxt = S_PY;
			end
			S_PY: begin
				op_a      = MW'(view_scale_q);
				op_b      = MW'(y_q);
				mul_en    = 1'b1;
				state_nxt = S_PX;
			end
			S_PX: begin
				op_a      = MW'(view_scale_q);
				op_b      = MW'(x_q);
				mul_en    = 1'b1;
				state_nxt = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					load_out  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	nsp_sine_rom #(
		.FRAC_BITS        (FRAC_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_sine (
		.clk   (clk),
		.idx   (sine_idx),
		.value (sine_val)
	);

	nsp_mul #(
		.W (MW)
	) u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (op_a),
		.b    (op_b),
		.prod (prod)
	);

	always_comb begin
		biased     = prod + HALF;
		floor_full = biased >>> FRAC_BITS;
		rnd_v      = floor_full[SW-1:0];
		mag_full   = biased[PW-1] ? -biased : biased;
		shift_full = mag_full >>> FRAC_BITS;
		proj_full  = biased[PW-1] ? -shift_full : shift_full;
		px_c       = proj_full[COORD_W-1:0];
	end

	function automatic logic signed [COORD_W-1:0] sat(logic signed [CENTER_W+1:0] v);
		if (v > 14'sd4095)
			return 13'sd4095;
		else if (v < -14'sd4096)
			return -13'sd4096;
		else
			return v[COORD_W-1:0];
	endfunction

	always_comb begin
		sum_fc = $signed({2'b00, center_first_x_q}) + (CENTER_W+2)'(py_q);
		sum_fr = $signed({2'b00, center_row_q}) - (CENTER_W+2)'(pz_q);
		sum_sc = $signed({2'b00, center_second_x_q}) + (CENTER_W+2)'(px_c);
		sum_sr = $signed({2'b00, center_row_q}) - (CENTER_W+2)'(py_q);
		sum_tc = $signed({2'b00, center_third_x_q}) + (CENTER_W+2)'(pz_q);
		sum_tr = $signed({2'b00, center_row_q}) - (CENTER_W+2)'(px_c);
		fc = sat(sum_fc);
		fr = sat(sum_fr);
		sc = sat(sum_sc);
		sr = sat(sum_sr);
		tc = sat(sum_tc);
		tr = sat(sum_tr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_scale_q      <= SCALE_W'(106);
			center_first_x_q  <= CENTER_W'(106);
			center_second_x_q <= CENTER_W'(320);
			center_third_x_q  <= CENTER_W'(533);
			center_row_q      <= CENTER_W'(240);
			oldest_byte_q     <= '0;
			middle_byte_q     <= '0;
			bytes_seen_q      <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VIEW_SCALE:      view_scale_q      <= cfg_data[SCALE_W-1:0];
					REG_CENTER_FIRST_X:  center_first_x_q  <= cfg_data;
					REG_CENTER_SECOND_X: center_second_x_q <= cfg_data;
					REG_CENTER_THIRD_X:  center_third_x_q  <= cfg_data;
					REG_CENTER_ROW:      center_row_q      <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				oldest_byte_q <= middle_byte_q;
				middle_byte_q <= s_tdata;
				if (bytes_seen_q != SEEN_FULL) begin
					bytes_seen_q <= bytes_seen_q + 2'd1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q         <= s_tdata;
			phi_idx_q   <= IW'(oldest_byte_q) * PHI_MUL_I;
			theta_idx_q <= IW'(middle_byte_q) * THETA_MUL_I;
		end
		case (state_q)
			S_LOAD: r_q  <= root_rom[c_q];
			S_RZ:   rs_q <= rnd_v;
			S_Y:    z_q  <= rnd_v;
			S_X:    y_q  <= rnd_v;
			S_PZ:   x_q  <= rnd_v;
			S_PY:   pz_q <= px_c;
			S_PX:   py_q <= px_c;
			default: ;
		endcase
		if (load_out) begin
			out_data_q <= {2'b00, tr, tc, sr, sc, fr, fc};
		end
	end

	a_out_from_sequencer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_OUT)
		else $error("output became valid without a finished point");

	a_history_only: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && bytes_seen_q != SEEN_FULL |=> state_q == S_IDLE)
		else $error("point started before three bytes were seen");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && m_tvalid && !m_tready |=> state_q == S_OUT)
		else $error("finished point dropped while the output was stalled");

	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_seen_q != 2'd3)
		else $error("byte counter passed its saturation value");

endmodule

`default_nettype wire
